// ===== sv/door_open_alarm_monitor_assert.svh =====
// Assertion macros used by the door alarm monitor checker.
// Expects signals named clk and arst_n in the scope of each use.
`ifndef DOOR_OPEN_ALARM_MONITOR_ASSERT_SVH
`define DOOR_OPEN_ALARM_MONITOR_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define DOAM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define DOAM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/doam_pkg.sv =====
// Shared types and constants of the door alarm monitor.
// No dependencies; the front end, queue, back end, top level and bench refer to it by scoped names.
package doam_pkg;

	localparam int QDEPTH = 2;
	localparam int PTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W  = $clog2(QDEPTH + 1);
	localparam int IDX_W  = 3;
	localparam int ELAPSED_W = 26;

	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};
	localparam logic [ELAPSED_W-1:0] LIMIT_RESET = 26'd10000;
	localparam logic [ELAPSED_W-1:0] MS_PER_S    = 26'd1000;

	localparam logic [7:0] SYNC_BYTE   = 8'hAA;
	localparam logic [7:0] ZERO_BYTE   = 8'h00;
	localparam logic [7:0] OP_REPORT   = 8'h10;
	localparam logic [7:0] OP_STARTUP  = 8'h02;
	localparam logic [7:0] OP_ONLINE   = 8'h05;
	localparam logic [7:0] OP_SETUP    = 8'h01;
	localparam logic [7:0] SIZE_REPORT = 8'h04;
	localparam logic [7:0] SIZE_START  = 8'h01;
	localparam logic [7:0] SIZE_ONLINE = 8'h00;
	localparam logic [7:0] MODE_ON     = 8'h01;
	localparam logic [7:0] MODE_OFF    = 8'h00;
	localparam logic [7:0] NODE_RESET  = 8'h01;

	localparam logic [IDX_W-1:0] LAST_REPORT = 3'd7;
	localparam logic [IDX_W-1:0] LAST_SHORT  = 3'd4;
	localparam logic [IDX_W-1:0] LAST_IDLE   = 3'd0;

	localparam logic [1:0] STAT_CLOSED = 2'd0;
	localparam logic [1:0] STAT_OPEN   = 2'd1;
	localparam logic [1:0] STAT_LATE   = 2'd2;

	typedef enum logic [1:0] {
		REQ_TICK     = 2'd0,
		REQ_RX       = 2'd1,
		REQ_ANNOUNCE = 2'd2,
		REQ_NONE     = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		DS_CLOSED = 3'b001,
		DS_OPEN   = 3'b010,
		DS_LATE   = 3'b100
	} door_t;

	typedef enum logic [1:0] {
		PK_IDLE    = 2'd0,
		PK_REPORT  = 2'd1,
		PK_STARTUP = 2'd2,
		PK_ONLINE  = 2'd3
	} pkt_kind_t;

	// One queued job: which packet to send plus the status after the item.
	typedef struct packed {
		pkt_kind_t   kind;
		logic [7:0]  node;
		logic [15:0] dur;
		logic        late;
		logic        alarm;
		logic [1:0]  status;
	} desc_t;

endpackage

// ===== sv/doam_front.sv =====
// Front end: accepts items, runs the door and frame state, issues packet jobs.
// Depends on doam_pkg.
module doam_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic               door_open,
	input  logic [7:0]         rx_byte,
	input  logic [7:0]         node_id,
	output logic               push_valid,
	input  logic               push_ready,
	output doam_pkg::desc_t    push_desc
);

	doam_pkg::door_t                     door_q, door_d;
	logic [doam_pkg::ELAPSED_W-1:0]      elapsed_q, elapsed_d, elapsed_inc;
	logic [doam_pkg::ELAPSED_W-1:0]      limit_q, limit_d, setup_limit;
	logic [7:0]                          mode_q, mode_d;
	logic                                alarm_q, alarm_d;
	logic [2:0]                          fidx_q, fidx_d;
	logic [7:0]                          frame_q [7];
	logic                                over;
	logic                                setup_hit, online_hit;
	logic                                accept;
	doam_pkg::req_t                      req;
	doam_pkg::pkt_kind_t                 kind;
	logic [1:0]                          status_d;

	assign in_ready   = push_ready;
	assign accept     = in_valid && push_ready;
	assign push_valid = in_valid;
	assign req        = doam_pkg::req_t'(req_type);

	assign elapsed_inc = (elapsed_q == doam_pkg::ELAPSED_MAX) ? elapsed_q
		: elapsed_q + doam_pkg::ELAPSED_W'(1);
	assign over        = elapsed_inc > limit_q;
	assign setup_limit = doam_pkg::ELAPSED_W'({frame_q[4], frame_q[5]}) * doam_pkg::MS_PER_S;

	// Seventh byte of a frame decodes straight from the wire.
	assign setup_hit  = (frame_q[0] == doam_pkg::OP_SETUP) && (frame_q[1] == doam_pkg::ZERO_BYTE)
		&& (frame_q[2] == doam_pkg::SIZE_REPORT) && (frame_q[3] == node_id);
	assign online_hit = (frame_q[0] == doam_pkg::OP_ONLINE) && (frame_q[1] == doam_pkg::ZERO_BYTE)
		&& (frame_q[2] == doam_pkg::ZERO_BYTE);

	always_comb begin
		door_d    = door_q;
		elapsed_d = elapsed_q;
		limit_d   = limit_q;
		mode_d    = mode_q;
		alarm_d   = alarm_q;
		fidx_d    = fidx_q;
		kind      = doam_pkg::PK_IDLE;
		unique case (req)
			doam_pkg::REQ_TICK: begin
				unique case (door_q)
					doam_pkg::DS_OPEN: begin
						elapsed_d = elapsed_inc;
						if (door_open) begin
							if (over) begin
								kind      = doam_pkg::PK_REPORT;
								elapsed_d = '0;
								door_d    = doam_pkg::DS_LATE;
								if (mode_q == doam_pkg::MODE_ON) alarm_d = 1'b1;
							end
						end else begin
							kind      = doam_pkg::PK_REPORT;
							elapsed_d = '0;
							door_d    = doam_pkg::DS_CLOSED;
						end
					end
					doam_pkg::DS_LATE: begin
						if (!door_open) door_d = doam_pkg::DS_CLOSED;
						if (mode_q == doam_pkg::MODE_ON) alarm_d = 1'b1;
						else if (mode_q == doam_pkg::MODE_OFF) alarm_d = 1'b0;
					end
					default: begin
						alarm_d = 1'b0;
						door_d  = doam_pkg::DS_CLOSED;
						if (door_open) begin
							door_d    = doam_pkg::DS_OPEN;
							elapsed_d = '0;
						end
					end
				endcase
			end
			doam_pkg::REQ_RX: begin
				if (fidx_q == 3'd0) begin
					if (rx_byte == doam_pkg::SYNC_BYTE) fidx_d = 3'd1;
				end else if (fidx_q == 3'd7) begin
					fidx_d = 3'd0;
					if (setup_hit) begin
						mode_d  = rx_byte;
						limit_d = setup_limit;
					end else if (online_hit) begin
						kind = doam_pkg::PK_ONLINE;
					end
				end else begin
					fidx_d = fidx_q + 3'd1;
				end
			end
			doam_pkg::REQ_ANNOUNCE: kind = doam_pkg::PK_STARTUP;
			doam_pkg::REQ_NONE:     kind = doam_pkg::PK_IDLE;
		endcase
	end

	always_comb begin
		unique case (door_d)
			doam_pkg::DS_OPEN: status_d = doam_pkg::STAT_OPEN;
			doam_pkg::DS_LATE: status_d = doam_pkg::STAT_LATE;
			default:           status_d = doam_pkg::STAT_CLOSED;
		endcase
	end

	// Report carries the count before it clears.
	assign push_desc = '{kind: kind, node: node_id, dur: elapsed_inc[15:0], late: over,
		alarm: alarm_d, status: status_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			door_q    <= doam_pkg::DS_CLOSED;
			elapsed_q <= '0;
			limit_q   <= doam_pkg::LIMIT_RESET;
			mode_q    <= doam_pkg::MODE_ON;
			alarm_q   <= 1'b0;
			fidx_q    <= 3'd0;
		end else if (accept) begin
			door_q    <= door_d;
			elapsed_q <= elapsed_d;
			limit_q   <= limit_d;
			mode_q    <= mode_d;
			alarm_q   <= alarm_d;
			fidx_q    <= fidx_d;
		end
	end

	// Frame bytes hold no reset; the first six land here before a decode, the seventh is used from the wire.
	always_ff @(posedge clk) begin
		if (accept && (req == doam_pkg::REQ_RX) && (fidx_q != 3'd0)) begin
			frame_q[fidx_q - 3'd1] <= rx_byte;
		end
	end

endmodule

// ===== sv/doam_queue.sv =====
// Short job queue between the front end and the byte serializer.
// Depends on doam_pkg.
module doam_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  doam_pkg::desc_t push_desc,
	output logic            pop_valid,
	input  logic            pop_ready,
	output doam_pkg::desc_t pop_desc
);

	doam_pkg::desc_t                 mem_q [doam_pkg::QDEPTH];
	logic [doam_pkg::PTR_W-1:0]      wr_ptr_q, rd_ptr_q;
	logic [doam_pkg::CNT_W-1:0]      cnt_q;
	logic                            push, pop;

	assign push_ready = cnt_q != doam_pkg::CNT_W'(doam_pkg::QDEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_desc   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	function automatic logic [doam_pkg::PTR_W-1:0] bump(input logic [doam_pkg::PTR_W-1:0] p);
		logic [doam_pkg::PTR_W-1:0] r;
		if (p == doam_pkg::PTR_W'(doam_pkg::QDEPTH - 1)) r = '0;
		else r = p + doam_pkg::PTR_W'(1);
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= bump(wr_ptr_q);
			if (pop)  rd_ptr_q <= bump(rd_ptr_q);
			if (push && !pop)      cnt_q <= cnt_q + doam_pkg::CNT_W'(1);
			else if (pop && !push) cnt_q <= cnt_q - doam_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_desc;
	end

endmodule

// ===== sv/doam_back.sv =====
// Back end: turns one queued job into its packet beats, one byte a cycle while out_ready is high.
// Depends on doam_pkg.
module doam_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  doam_pkg::desc_t pop_desc,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_byte,
	output logic            byte_valid,
	output logic            last,
	output logic            alarm_on,
	output logic [1:0]      door_status
);

	doam_pkg::desc_t             cur_q;
	logic                        cur_vld_q;
	logic [doam_pkg::IDX_W-1:0]  idx_q;
	logic [doam_pkg::IDX_W-1:0]  last_idx;
	logic [7:0]                  op_byte, size_byte;
	logic                        done;

	always_comb begin
		unique case (cur_q.kind)
			doam_pkg::PK_REPORT: begin
				last_idx  = doam_pkg::LAST_REPORT;
				op_byte   = doam_pkg::OP_REPORT;
				size_byte = doam_pkg::SIZE_REPORT;
			end
			doam_pkg::PK_STARTUP: begin
				last_idx  = doam_pkg::LAST_SHORT;
				op_byte   = doam_pkg::OP_STARTUP;
				size_byte = doam_pkg::SIZE_START;
			end
			doam_pkg::PK_ONLINE: begin
				last_idx  = doam_pkg::LAST_SHORT;
				op_byte   = doam_pkg::OP_ONLINE;
				size_byte = doam_pkg::SIZE_ONLINE;
			end
			doam_pkg::PK_IDLE: begin
				last_idx  = doam_pkg::LAST_IDLE;
				op_byte   = doam_pkg::ZERO_BYTE;
				size_byte = doam_pkg::ZERO_BYTE;
			end
		endcase
	end

	always_comb begin
		unique case (idx_q)
			3'd0:    out_byte = (cur_q.kind == doam_pkg::PK_IDLE) ? doam_pkg::ZERO_BYTE
				: doam_pkg::SYNC_BYTE;
			3'd1:    out_byte = op_byte;
			3'd2:    out_byte = doam_pkg::ZERO_BYTE;
			3'd3:    out_byte = size_byte;
			3'd4:    out_byte = cur_q.node;
			3'd5:    out_byte = cur_q.dur[15:8];
			3'd6:    out_byte = cur_q.dur[7:0];
			default: out_byte = {7'd0, cur_q.late};
		endcase
	end

	assign out_valid   = cur_vld_q;
	assign byte_valid  = cur_q.kind != doam_pkg::PK_IDLE;
	assign last        = idx_q == last_idx;
	assign alarm_on    = cur_q.alarm;
	assign door_status = cur_q.status;
	assign done        = cur_vld_q && out_ready && last;
	assign pop_ready   = !cur_vld_q || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
			idx_q     <= '0;
		end else begin
			priority if (pop_ready && pop_valid) begin
				cur_vld_q <= 1'b1;
				idx_q     <= '0;
			end else if (done) begin
				cur_vld_q <= 1'b0;
			end else if (cur_vld_q && out_ready) begin
				idx_q <= idx_q + doam_pkg::IDX_W'(1);
			end else begin
				// hold the current beat
				idx_q <= idx_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (pop_ready && pop_valid) begin
			cur_q <= pop_desc;
		end
	end

endmodule

// ===== sv/door_open_alarm_monitor.sv =====
// Door-open alarm monitor, top level.
// Channels: in (valid/ready) takes one request beat: req_type selects a
//   millisecond tick with door_open, a received serial byte in rx_byte, or a
//   startup announce. cfg (valid/ready, always ready) writes node_id.
// out (valid/ready) gives result beats: packet bytes with byte_valid set, or
//   one idle beat (out_byte 0) for an item that sends nothing. last marks the
//   final beat of an item; alarm_on and door_status show the state after it.
// Path: an accepted item is written to the job queue, then loaded into the
//   serializer register that drives out_valid for its first beat.
// Throughput: the front end takes one item per cycle while the two-entry job
//   queue has room; the serializer emits one beat per cycle while out_ready is
//   high. An item has 8 beats for a door report, 5 for a short packet, 1 otherwise.
// Stall: when out_ready is low the current beat holds; the queue absorbs two
//   further items, then in_ready drops until beats drain.
// Reset: door closed, elapsed 0, limit 10000 ms, alarm mode 1, alarm off,
//   frame hunter waiting for sync, node_id 1, queue and serializer empty.
// Depends on doam_pkg, doam_front, doam_queue, doam_back.
module door_open_alarm_monitor (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] req_type,
	input  logic       door_open,
	input  logic [7:0] rx_byte,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       last,
	output logic       alarm_on,
	output logic [1:0] door_status
);

	logic [7:0]      node_id_q;
	logic            push_valid, push_ready;
	logic            pop_valid, pop_ready;
	doam_pkg::desc_t push_desc, pop_desc;

	// Config writes must land only while idle; the block does not enforce it and ties cfg_ready high.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q <= doam_pkg::NODE_RESET;
		end else if (cfg_valid) begin
			node_id_q <= cfg_data;
		end
	end

	// Classify and update state; issue a packet job per accepted item.
	doam_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.door_open  (door_open),
		.rx_byte    (rx_byte),
		.node_id    (node_id_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_desc  (push_desc)
	);

	// Decouple the front end from the serializer.
	doam_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_desc  (push_desc),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_desc   (pop_desc)
	);

	// Advance one beat per cycle the receiver takes.
	doam_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_desc    (pop_desc),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.byte_valid  (byte_valid),
		.last        (last),
		.alarm_on    (alarm_on),
		.door_status (door_status)
	);

endmodule

// ===== sv/doam_checker.sv =====
// Port-level checks of the door alarm monitor, bound to the top level.
// Depends on door_open_alarm_monitor_assert.svh.
`include "door_open_alarm_monitor_assert.svh"

module doam_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       byte_valid,
	input logic       last,
	input logic [1:0] door_status
);

	// A stalled beat holds.
	`DOAM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(last), "out beat changed while stalled")

	// An idle beat is a whole result by itself.
	`DOAM_ASSERT_NOW(a_idle_last, out_valid && !byte_valid, last && (out_byte == 8'h00), "idle beat not last or not zero")

	// Packet bytes follow back to back until the last one.
	`DOAM_ASSERT_NEXT(a_pkt_cont, out_valid && out_ready && byte_valid && !last, out_valid && byte_valid, "packet broken before last byte")

	// Status never shows the unused code.
	`DOAM_ASSERT_NOW(a_status_code, out_valid, door_status != 2'd3, "door status code out of range")

endmodule

bind door_open_alarm_monitor doam_checker u_doam_checker (.*);

// ===== verif/door_open_alarm_monitor_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for door_open_alarm_monitor: random valid/ready traffic on
// both channels, node_id writes between phases, and a beat-by-beat prediction.
// Depends on doam_pkg and the door_open_alarm_monitor RTL.

module door_open_alarm_monitor_tb;

	localparam int LONG_HOLD      = 64;   // receiver hold-off that fills the job queue
	localparam int WATCHDOG_LIMIT = 3000; // cycles with no beat on any channel
	localparam int PHASE_ITEMS    = 55;   // random request beats per node_id setting
	localparam int TAIL_CYCLES    = 16;   // quiet wait for stray beats at the end
	localparam int MAX_REPORTS    = 40;   // cap on printed mismatch lines

	// One result beat as it leaves the block.
	typedef struct packed {
		logic [7:0] data;
		logic       is_byte;
		logic       tail;
		logic       alarm;
		logic [1:0] status;
	} beat_t;

	// Scoreboard: tracks door, timer, frame hunter and node_id, and keeps
	// the result beats still owed by the block in arrival order.
	class alarm_beat_ledger;
		logic [7:0]  node;
		logic [1:0]  door;
		logic [25:0] elapsed;
		logic [25:0] limit;
		logic [7:0]  mode;
		logic        alarm;
		logic [7:0]  frame [7];
		int          frame_pos;
		logic [7:0]  tx [$];
		beat_t       owed_beats [$];
		int          errors;
		int          requests;
		int          beats;
		int          reports;
		int          late_reports;
		int          shorts;

		function new();
			node      = doam_pkg::NODE_RESET;
			door      = doam_pkg::STAT_CLOSED;
			elapsed   = '0;
			limit     = doam_pkg::LIMIT_RESET;
			mode      = doam_pkg::MODE_ON;
			alarm     = 1'b0;
			frame_pos = 0;
			foreach (frame[i]) frame[i] = doam_pkg::ZERO_BYTE;
		endfunction

		function void queue_report();
			tx.push_back(doam_pkg::SYNC_BYTE);
			tx.push_back(doam_pkg::OP_REPORT);
			tx.push_back(doam_pkg::ZERO_BYTE);
			tx.push_back(doam_pkg::SIZE_REPORT);
			tx.push_back(node);
			tx.push_back(elapsed[15:8]);
			tx.push_back(elapsed[7:0]);
			tx.push_back({7'd0, elapsed > limit});
			reports++;
			if (elapsed > limit) late_reports++;
		endfunction

		function void queue_short(logic [7:0] op, logic [7:0] size);
			tx.push_back(doam_pkg::SYNC_BYTE);
			tx.push_back(op);
			tx.push_back(doam_pkg::ZERO_BYTE);
			tx.push_back(size);
			tx.push_back(node);
			shorts++;
		endfunction

		function void tick_door(logic open);
			if (door != doam_pkg::STAT_OPEN && door != doam_pkg::STAT_LATE) begin
				// closed, and any stray code treated as closed
				alarm = 1'b0;
				door  = doam_pkg::STAT_CLOSED;
				if (open) begin
					door    = doam_pkg::STAT_OPEN;
					elapsed = '0;
				end
			end else if (door == doam_pkg::STAT_OPEN) begin
				if (elapsed < doam_pkg::ELAPSED_MAX) elapsed = elapsed + 1'b1;
				if (!open) begin
					// report carries late 1 when the limit was lowered under us
					queue_report();
					door    = doam_pkg::STAT_CLOSED;
					elapsed = '0;
				end else if (elapsed > limit) begin
					queue_report();
					elapsed = '0;
					if (mode == doam_pkg::MODE_ON) alarm = 1'b1;
					door = doam_pkg::STAT_LATE;
				end
			end else begin
				if (!open) door = doam_pkg::STAT_CLOSED;
				if (mode == doam_pkg::MODE_ON) alarm = 1'b1;
				else if (mode == doam_pkg::MODE_OFF) alarm = 1'b0;
			end
		endfunction

		function void apply_frame();
			if (frame[0] == doam_pkg::OP_SETUP && frame[1] == doam_pkg::ZERO_BYTE &&
					frame[2] == doam_pkg::SIZE_REPORT && frame[3] == node) begin
				mode  = frame[6];
				limit = 26'({frame[4], frame[5]}) * doam_pkg::MS_PER_S;
			end else if (frame[0] == doam_pkg::OP_ONLINE && frame[1] == doam_pkg::ZERO_BYTE &&
					frame[2] == doam_pkg::SIZE_ONLINE) begin
				queue_short(doam_pkg::OP_ONLINE, doam_pkg::SIZE_ONLINE);
			end
		endfunction

		function void take_rx(logic [7:0] b);
			if (frame_pos == 0) begin
				if (b == doam_pkg::SYNC_BYTE) frame_pos = 1;
			end else begin
				frame[frame_pos - 1] = b;
				if (frame_pos == 7) begin
					frame_pos = 0;
					apply_frame();
				end else begin
					frame_pos++;
				end
			end
		endfunction

		// Note one accepted request beat and queue the result beats it owes.
		function void take_request(logic [1:0] req, logic open, logic [7:0] b);
			tx.delete();
			requests++;
			case (req)
				doam_pkg::REQ_TICK:     tick_door(open);
				doam_pkg::REQ_RX:       take_rx(b);
				doam_pkg::REQ_ANNOUNCE: queue_short(doam_pkg::OP_STARTUP, doam_pkg::SIZE_START);
				default:                ;
			endcase
			if (tx.size() == 0) begin
				owed_beats.push_back(beat_t'{doam_pkg::ZERO_BYTE, 1'b0, 1'b1, alarm, door});
			end else begin
				foreach (tx[k])
					owed_beats.push_back(beat_t'{tx[k], 1'b1, (k == tx.size() - 1), alarm, door});
			end
		endfunction

		function void flag(string field, logic [7:0] want, logic [7:0] got);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s mismatch on result beat %0d, expected %0h, actual %0h",
					$time, field, beats, want, got);
		endfunction

		// Compare one accepted result beat with the oldest owed beat.
		function void match_beat(beat_t got);
			beat_t want;
			if (owed_beats.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected result beat, expected none, actual byte %0h valid %0b",
						$time, got.data, got.is_byte);
				return;
			end
			want = owed_beats.pop_front();
			beats++;
			if (got.data !== want.data)       flag("out_byte", want.data, got.data);
			if (got.is_byte !== want.is_byte) flag("byte_valid", want.is_byte, got.is_byte);
			if (got.tail !== want.tail)       flag("last", want.tail, got.tail);
			if (got.alarm !== want.alarm)     flag("alarm_on", want.alarm, got.alarm);
			if (got.status !== want.status)   flag("door_status", want.status, got.status);
		endfunction

		function int owed();
			return owed_beats.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] req_type;
	logic       door_open;
	logic [7:0] rx_byte;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [7:0] cfg_data;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       last;
	logic       alarm_on;
	logic [1:0] door_status;

	alarm_beat_ledger ledger;

	logic [7:0] cur_node     = doam_pkg::NODE_RESET; // node_id as last written
	int         rx_pos       = 0;          // frame position as the sender sees it
	logic       door_level   = 1'b0;       // sticky door level for random ticks
	int         items_sent   = 0;
	int         cfg_writes   = 0;
	int         quiet_cycles = 0;
	bit         steady       = 1'b0;       // both sides run without gaps
	bit         hold_req     = 1'b0;       // ask the receiver for one long hold-off

	door_open_alarm_monitor i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Sample every channel at the rising edge: check result beats first, then
	// note the request beat; a beat accepted now cannot answer this request.
	// The same block keeps the no-progress watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				ledger.match_beat(beat_t'{out_byte, byte_valid, last, alarm_on, door_status});
			if (in_valid && in_ready)
				ledger.take_request(req_type, door_open, rx_byte);
			if (cfg_valid && cfg_ready)
				ledger.node = cfg_data;
			if ((out_valid && out_ready) || (in_valid && in_ready) || (cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles == WATCHDOG_LIMIT) begin
					$display("%0t: watchdog, no beat for %0d cycles, %0d result beats still owed",
						$time, WATCHDOG_LIMIT, ledger.owed());
					$display("door_open_alarm_monitor_tb: done, errors");
					$finish;
				end
			end
		end
	end

	// Gap length for either side: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || hold_req) return 0;
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 10);
		return $urandom_range(20, 45);
	endfunction

	// Receiver: drop ready for random stretches at the falling edge; serve a
	// long hold-off when asked, counted here so the sender keeps pushing.
	initial begin
		int stall;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_req = 1'b0;
				out_ready <= 1'b1;
			end else begin
				stall = pick_gap();
				if (stall == 0) begin
					out_ready <= 1'b1;
				end else begin
					out_ready <= 1'b0;
					repeat (stall) @(negedge clk);
					out_ready <= 1'b1;
				end
			end
		end
	end

	// Offer one request beat after a random gap and hold it until taken.
	// Valid stays high straight into the next beat when there is no gap.
	task automatic send_item(doam_pkg::req_t r, logic open, logic [7:0] b);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		req_type  <= r;
		door_open <= open;
		rx_byte   <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	// Drop valid right after the last accepted beat of a run.
	task automatic in_idle();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic tick(logic open);
		send_item(doam_pkg::REQ_TICK, open, 8'($urandom_range(0, 255)));
	endtask

	// Send one serial byte and advance the sender's copy of the frame position.
	task automatic send_rx(logic [7:0] b);
		if (rx_pos == 0) rx_pos = (b == doam_pkg::SYNC_BYTE) ? 1 : 0;
		else rx_pos = (rx_pos == 7) ? 0 : rx_pos + 1;
		send_item(doam_pkg::REQ_RX, 1'($urandom_range(0, 1)), b);
	endtask

	// Finish any partial frame with filler, then send sync and seven bytes.
	task automatic send_frame(logic [55:0] body);
		while (rx_pos != 0) send_rx(8'($urandom_range(0, 255)));
		send_rx(doam_pkg::SYNC_BYTE);
		for (int i = 6; i >= 0; i--) send_rx(body[8*i +: 8]);
	endtask

	task automatic setup_frame(logic [7:0] node, logic [15:0] secs, logic [7:0] mode);
		send_frame({doam_pkg::OP_SETUP, doam_pkg::ZERO_BYTE, doam_pkg::SIZE_REPORT, node, secs,
			mode});
	endtask

	task automatic online_frame();
		send_frame({doam_pkg::OP_ONLINE, doam_pkg::ZERO_BYTE, doam_pkg::SIZE_ONLINE,
			32'($urandom)});
	endtask

	// Wait until every owed result beat has come back.
	task automatic drain();
		in_idle();
		while (ledger.owed() != 0) @(posedge clk);
	endtask

	// Write node_id only with the block idle.
	task automatic write_node(logic [7:0] v);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cur_node = v;
		cfg_writes++;
	endtask

	// Mostly ticks and well-formed frames with random content; the rest is
	// wrong-node setups, cut-off frames, loose bytes, announces and unused codes.
	task automatic random_phase(int count);
		int stop;
		int pick;
		int len;
		logic [15:0] secs;
		logic [7:0]  mode;
		logic [7:0]  node;
		stop = items_sent + count;
		while (items_sent < stop) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				if ($urandom_range(0, 4) == 0) door_level = ~door_level;
				tick(door_level);
			end else if (pick < 58) begin
				node = ($urandom_range(0, 9) == 0) ? 8'($urandom) : cur_node;
				case ($urandom_range(0, 3))
					0, 1:    secs = '0;
					2:       secs = 16'($urandom_range(1, 3));
					default: secs = 16'($urandom);
				endcase
				case ($urandom_range(0, 2))
					0:       mode = doam_pkg::MODE_ON;
					1:       mode = doam_pkg::MODE_OFF;
					default: mode = 8'($urandom);
				endcase
				setup_frame(node, secs, mode);
			end else if (pick < 68) begin
				online_frame();
			end else if (pick < 75) begin
				len = $urandom_range(0, 6);
				send_rx(doam_pkg::SYNC_BYTE);
				repeat (len) send_rx(8'($urandom));
			end else if (pick < 84) begin
				send_rx(8'($urandom));
			end else if (pick < 93) begin
				send_item(doam_pkg::REQ_ANNOUNCE, 1'($urandom_range(0, 1)), 8'($urandom));
			end else begin
				send_item(doam_pkg::REQ_NONE, 1'($urandom_range(0, 1)), 8'($urandom));
			end
		end
	endtask

	initial begin
		ledger    = new();
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		req_type  = doam_pkg::REQ_NONE;
		door_open = 1'b0;
		rx_byte   = 8'h00;
		cfg_valid = 1'b0;
		cfg_data  = 8'h00;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: announce, unused code, loose byte while hunting, then limit 0
		// so the door goes late at once, close from late, and a late close
		// straight from open; end with an online request.
		send_item(doam_pkg::REQ_ANNOUNCE, 1'b1, 8'hFF);
		send_item(doam_pkg::REQ_NONE, 1'b0, 8'h00);
		send_rx(8'h55);
		tick(1'b0);
		setup_frame(cur_node, 16'd0, doam_pkg::MODE_ON);
		tick(1'b1);
		tick(1'b1);
		tick(1'b0);
		tick(1'b0);
		tick(1'b1);
		tick(1'b0);
		online_frame();

		// Node 0: go late with the alarm on, clear it with mode off under the
		// widest limit, then open and close in time.
		write_node(8'h00);
		setup_frame(8'h00, 16'd0, doam_pkg::MODE_ON);
		repeat (3) tick(1'b1);
		setup_frame(8'h00, 16'hFFFF, doam_pkg::MODE_OFF);
		tick(1'b1);
		tick(1'b0);
		repeat (10) tick(1'b1);
		tick(1'b0);

		// Node 255: mid-phase, hold the receiver off so the queue fills.
		write_node(8'hFF);
		random_phase(PHASE_ITEMS / 2);
		hold_req = 1'b1;
		random_phase(PHASE_ITEMS - PHASE_ITEMS / 2);

		// Random node: open with a gap-free stretch on both sides.
		write_node(8'($urandom));
		steady = 1'b1;
		random_phase(20);
		steady = 1'b0;
		random_phase(PHASE_ITEMS - 20);

		repeat (2) begin
			write_node(8'($urandom));
			random_phase(PHASE_ITEMS);
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d request beats and %0d result beats over %0d node_id settings",
			ledger.requests, ledger.beats, cfg_writes + 1);
		$display("seen %0d door reports (%0d late) and %0d short packets, one %0d-cycle hold-off",
			ledger.reports, ledger.late_reports, ledger.shorts, LONG_HOLD);
		if (ledger.errors == 0)
			$display("door_open_alarm_monitor_tb: done, clean");
		else
			$display("door_open_alarm_monitor_tb: done, errors");
		$finish;
	end

endmodule
